@@ rtl/csibf_pkg.sv @@
package csibf_pkg;

    localparam int SUBCARRIERS  = 30;
    localparam int HEADER_BYTES = 20;
    localparam int MAX_ANTENNAS = 3;

    localparam logic [7:0] RECORD_CODE_RESET = 8'd187;
    localparam int         SKIP_BITS         = 3;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_VALUE    = 2'd1,
        KIND_MISMATCH = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [7:0]  csi_value;
        logic [4:0]         subcarrier;
        logic [3:0]         pair_index;
        logic               is_imag;
        logic [31:0]        timestamp;
        logic [15:0]        beamforming_count;
        logic [7:0]         rx_antennas;
        logic [7:0]         tx_antennas;
        logic [23:0]        rssi_triplet;
        logic [7:0]         noise_level;
        logic [5:0]         antenna_order;
    } result_t;

    // payload bytes for a given number of antenna pairs
    function automatic logic [15:0] expected_len(input logic [3:0] pairs);
        logic [15:0] p;
        p = {12'b0, pairs};
        return (16'(SUBCARRIERS) * (p * 16'd16 + 16'(SKIP_BITS)) + 16'd7) >> 3;
    endfunction

endpackage

@@ rtl/csibf_parser.sv @@
module csibf_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          record_code,
    input  logic                in_fire,
    input  logic [7:0]          data_byte,
    output logic                emit,
    output csibf_pkg::result_t  res
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [9:0]  byte_counter_reg, byte_counter_next;
    logic [31:0] ts_reg, ts_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  rx_reg, rx_next;
    logic [7:0]  tx_reg, tx_next;
    logic [23:0] rssi_reg, rssi_next;
    logic [7:0]  noise_reg, noise_next;
    logic [5:0]  antsel_reg, antsel_next;
    logic [15:0] len_reg, len_next;
    logic [9:0]  payload_length_reg, payload_length_next;
    logic [15:0] bit_buffer_reg, bit_buffer_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic        skip_pending_reg, skip_pending_next;
    logic [4:0]  subcarrier_reg, subcarrier_next;
    logic [3:0]  pair_reg, pair_next;
    logic        imag_reg, imag_next;

    always_comb
    begin
        logic [15:0] bits_v;
        logic [3:0]  cnt_v;
        logic [3:0]  pairs_v;
        logic [9:0]  byte_inc;
        logic        len_ok;

        phase_next          = phase_reg;
        byte_counter_next   = byte_counter_reg;
        ts_next             = ts_reg;
        count_next          = count_reg;
        rx_next             = rx_reg;
        tx_next             = tx_reg;
        rssi_next           = rssi_reg;
        noise_next          = noise_reg;
        antsel_next         = antsel_reg;
        len_next            = len_reg;
        payload_length_next = payload_length_reg;
        bit_buffer_next     = bit_buffer_reg;
        bit_count_next      = bit_count_reg;
        skip_pending_next   = skip_pending_reg;
        subcarrier_next     = subcarrier_reg;
        pair_next           = pair_reg;
        imag_next           = imag_reg;

        emit                  = 1'b0;
        res.kind              = csibf_pkg::KIND_HEADER;
        res.csi_value         = '0;
        res.subcarrier        = '0;
        res.pair_index        = '0;
        res.is_imag           = 1'b0;
        res.timestamp         = ts_reg;
        res.beamforming_count = count_reg;
        res.rx_antennas       = rx_reg;
        res.tx_antennas       = tx_reg;
        res.rssi_triplet      = rssi_reg;
        res.noise_level       = noise_reg;
        res.antenna_order     = antsel_reg;

        byte_inc = byte_counter_reg + 10'd1;
        // counts are at most three once a record is in its payload
        pairs_v  = {2'b0, rx_reg[1:0]} * {2'b0, tx_reg[1:0]};
        bits_v   = bit_buffer_reg | (16'(data_byte) << bit_count_reg);
        cnt_v    = {1'b0, bit_count_reg} + 4'd8;
        len_ok   = 1'b0;

        if (in_fire)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (data_byte == record_code)
                    begin
                        phase_next        = PH_HEADER;
                        byte_counter_next = '0;
                    end
                end
                PH_HEADER:
                begin
                    byte_counter_next = byte_inc;
                    case (byte_counter_reg)
                        10'd0:   ts_next[7:0]      = data_byte;
                        10'd1:   ts_next[15:8]     = data_byte;
                        10'd2:   ts_next[23:16]    = data_byte;
                        10'd3:   ts_next[31:24]    = data_byte;
                        10'd4:   count_next[7:0]   = data_byte;
                        10'd5:   count_next[15:8]  = data_byte;
                        10'd8:   rx_next           = data_byte;
                        10'd9:   tx_next           = data_byte;
                        10'd10:  rssi_next[7:0]    = data_byte;
                        10'd11:  rssi_next[15:8]   = data_byte;
                        10'd12:  rssi_next[23:16]  = data_byte;
                        10'd13:  noise_next        = data_byte;
                        10'd15:  antsel_next       = data_byte[5:0];
                        10'd16:  len_next[7:0]     = data_byte;
                        10'd17:  len_next[15:8]    = data_byte;
                        default: ;
                    endcase
                    if (byte_counter_reg == 10'(csibf_pkg::HEADER_BYTES - 1))
                    begin
                        len_ok = (rx_reg <= 8'(csibf_pkg::MAX_ANTENNAS))
                              && (tx_reg <= 8'(csibf_pkg::MAX_ANTENNAS))
                              && (csibf_pkg::expected_len(pairs_v) == len_reg);
                        byte_counter_next = '0;
                        emit              = 1'b1;
                        if (!len_ok)
                        begin
                            phase_next = PH_HUNT;
                            res.kind   = csibf_pkg::KIND_MISMATCH;
                        end
                        else
                        begin
                            payload_length_next = len_reg[9:0];
                            bit_buffer_next     = '0;
                            bit_count_next      = '0;
                            skip_pending_next   = 1'b1;
                            subcarrier_next     = '0;
                            pair_next           = '0;
                            imag_next           = 1'b0;
                            phase_next = (len_reg == 16'd0) ? PH_HUNT : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (pairs_v != 4'd0
                        && subcarrier_reg < 5'(csibf_pkg::SUBCARRIERS))
                    begin
                        // the fresh byte always covers the three skipped bits
                        if (skip_pending_reg)
                        begin
                            bits_v            = bits_v >> csibf_pkg::SKIP_BITS;
                            cnt_v             = cnt_v - 4'(csibf_pkg::SKIP_BITS);
                            skip_pending_next = 1'b0;
                        end
                        if (cnt_v >= 4'd8)
                        begin
                            emit           = 1'b1;
                            res.kind       = csibf_pkg::KIND_VALUE;
                            res.csi_value  = bits_v[7:0];
                            res.subcarrier = subcarrier_reg;
                            res.pair_index = pair_reg;
                            res.is_imag    = imag_reg;
                            bits_v         = bits_v >> 8;
                            cnt_v          = cnt_v - 4'd8;
                            if (imag_reg)
                            begin
                                imag_next = 1'b0;
                                if (pair_reg + 4'd1 >= pairs_v)
                                begin
                                    pair_next         = '0;
                                    subcarrier_next   = subcarrier_reg + 5'd1;
                                    skip_pending_next = 1'b1;
                                end
                                else
                                begin
                                    pair_next = pair_reg + 4'd1;
                                end
                            end
                            else
                            begin
                                imag_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        bits_v = '0;
                        cnt_v  = '0;
                    end
                    bit_buffer_next   = bits_v;
                    bit_count_next    = cnt_v[2:0];
                    byte_counter_next = byte_inc;
                    if (byte_inc >= payload_length_reg)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT;
            byte_counter_reg   <= '0;
            ts_reg             <= '0;
            count_reg          <= '0;
            rx_reg             <= '0;
            tx_reg             <= '0;
            rssi_reg           <= '0;
            noise_reg          <= '0;
            antsel_reg         <= '0;
            len_reg            <= '0;
            payload_length_reg <= '0;
            bit_buffer_reg     <= '0;
            bit_count_reg      <= '0;
            skip_pending_reg   <= 1'b1;
            subcarrier_reg     <= '0;
            pair_reg           <= '0;
            imag_reg           <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            byte_counter_reg   <= byte_counter_next;
            ts_reg             <= ts_next;
            count_reg          <= count_next;
            rx_reg             <= rx_next;
            tx_reg             <= tx_next;
            rssi_reg           <= rssi_next;
            noise_reg          <= noise_next;
            antsel_reg         <= antsel_next;
            len_reg            <= len_next;
            payload_length_reg <= payload_length_next;
            bit_buffer_reg     <= bit_buffer_next;
            bit_count_reg      <= bit_count_next;
            skip_pending_reg   <= skip_pending_next;
            subcarrier_reg     <= subcarrier_next;
            pair_reg           <= pair_next;
            imag_reg           <= imag_next;
        end
    end

endmodule

@@ rtl/csi_beamforming_record_unpacker.sv @@
// channel  | handshake                | payload
// cfg      | cfg_valid / cfg_ready    | cfg_data (record code)
// input    | in_valid / in_ready      | data_byte
// output   | out_valid / out_ready    | kind, csi_value, position and header fields
//
// one byte is taken per cycle while in_ready is high; the result it causes is registered
// the byte is parsed straight into the result register; a one-entry skid register
// behind it lets a byte in while a result waits, in_ready drops only when both are full
// cfg_ready is always high; reset leaves the record code at 187 and hunting
module csi_beamforming_record_unpacker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic signed [7:0]  csi_value,
    output logic [4:0]         subcarrier,
    output logic [3:0]         pair_index,
    output logic               is_imag,
    output logic [31:0]        timestamp,
    output logic [15:0]        beamforming_count,
    output logic [7:0]         rx_antennas,
    output logic [7:0]         tx_antennas,
    output logic [23:0]        rssi_triplet,
    output logic [7:0]         noise_level,
    output logic [5:0]         antenna_order
);

    logic [7:0]          record_code_reg;
    logic                in_fire;
    logic                emit;
    logic                pop;
    csibf_pkg::result_t  res;
    csibf_pkg::result_t  out_reg;
    csibf_pkg::result_t  skid_reg;
    logic                out_valid_reg;
    logic                skid_valid_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_code_reg <= csibf_pkg::RECORD_CODE_RESET;
        end
        else if (cfg_valid)
        begin
            record_code_reg <= cfg_data;
        end
    end

    csibf_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .record_code (record_code_reg),
        .in_fire     (in_fire),
        .data_byte   (data_byte),
        .emit        (emit),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end
        else if (skid_valid_reg)
        begin
            // no new transaction enters while the skid entry is full
            if (pop)
            begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire && emit)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign kind              = out_reg.kind;
    assign csi_value         = out_reg.csi_value;
    assign subcarrier        = out_reg.subcarrier;
    assign pair_index        = out_reg.pair_index;
    assign is_imag           = out_reg.is_imag;
    assign timestamp         = out_reg.timestamp;
    assign beamforming_count = out_reg.beamforming_count;
    assign rx_antennas       = out_reg.rx_antennas;
    assign tx_antennas       = out_reg.tx_antennas;
    assign rssi_triplet      = out_reg.rssi_triplet;
    assign noise_level       = out_reg.noise_level;
    assign antenna_order     = out_reg.antenna_order;

endmodule

@@ rtl/csibf_checker.sv @@
module csibf_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         kind,
    input  logic signed [7:0]  csi_value,
    input  logic [4:0]         subcarrier,
    input  logic [3:0]         pair_index,
    input  logic               is_imag,
    input  logic [7:0]         rx_antennas,
    input  logic [7:0]         tx_antennas
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(csi_value)
            && $stable(subcarrier) && $stable(pair_index) && $stable(is_imag))
        else $error("stalled result changed");

    // header and mismatch results carry no channel position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == csibf_pkg::KIND_HEADER || kind == csibf_pkg::KIND_MISMATCH)
            |-> csi_value == 8'sd0 && subcarrier == 5'd0 && pair_index == 4'd0 && !is_imag)
        else $error("non-value result carries a position");

    // a channel value lies inside the grid of the accepted record
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == csibf_pkg::KIND_VALUE
            |-> subcarrier < 5'(csibf_pkg::SUBCARRIERS)
                && rx_antennas <= 8'(csibf_pkg::MAX_ANTENNAS)
                && tx_antennas <= 8'(csibf_pkg::MAX_ANTENNAS)
                && pair_index < ({2'b0, rx_antennas[1:0]} * {2'b0, tx_antennas[1:0]}))
        else $error("channel value outside the record grid");

    // the result kind never shows the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind != 2'd3)
        else $error("result kind out of range");

endmodule

bind csi_beamforming_record_unpacker csibf_checker u_csibf_checker (.*);

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [1:0] {
        HUNTING,
        IN_HEADER,
        IN_PAYLOAD
    } parse_state_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data  = 8'd0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [7:0]         data_byte = 8'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         kind;
    logic signed [7:0]  csi_value;
    logic [4:0]         subcarrier;
    logic [3:0]         pair_index;
    logic               is_imag;
    logic [31:0]        timestamp;
    logic [15:0]        beamforming_count;
    logic [7:0]         rx_antennas;
    logic [7:0]         tx_antennas;
    logic [23:0]        rssi_triplet;
    logic [7:0]         noise_level;
    logic [5:0]         antenna_order;

    // unpacker state as the testbench tracks it
    logic [7:0]         code_model = csibf_pkg::RECORD_CODE_RESET;
    parse_state_t       pstate     = HUNTING;
    int                 pos        = 0;
    logic [63:0]        hdr_lo     = '0;
    logic [63:0]        hdr_hi     = '0;
    logic [15:0]        pay_len    = '0;
    logic [15:0]        bit_buf    = '0;
    int                 bit_cnt    = 0;
    int                 skip_left  = csibf_pkg::SKIP_BITS;
    int                 sc_idx     = 0;
    int                 pair_idx   = 0;
    logic               imag_q     = 1'b0;

    csibf_pkg::result_t expected_results[$];
    csibf_pkg::result_t want_res;
    logic [7:0]         stream_q[$];
    int                 queued        = 0;
    int                 errors        = 0;
    int                 send_idle     = 26;
    int                 recv_idle     = 54;
    int                 results_taken = 0;
    int                 hold_left     = 0;
    int                 quiet         = 0;

    csi_beamforming_record_unpacker dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .kind              (kind),
        .csi_value         (csi_value),
        .subcarrier        (subcarrier),
        .pair_index        (pair_index),
        .is_imag           (is_imag),
        .timestamp         (timestamp),
        .beamforming_count (beamforming_count),
        .rx_antennas       (rx_antennas),
        .tx_antennas       (tx_antennas),
        .rssi_triplet      (rssi_triplet),
        .noise_level       (noise_level),
        .antenna_order     (antenna_order)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic csibf_pkg::result_t build_result(input csibf_pkg::kind_t k,
            input logic [7:0] v, input logic [4:0] s, input logic [3:0] p, input logic im);
        csibf_pkg::result_t r;
        r.kind              = k;
        r.csi_value         = v;
        r.subcarrier        = s;
        r.pair_index        = p;
        r.is_imag           = im;
        r.timestamp         = hdr_lo[31:0];
        r.beamforming_count = hdr_lo[47:32];
        r.rx_antennas       = hdr_lo[55:48];
        r.tx_antennas       = hdr_lo[63:56];
        r.rssi_triplet      = hdr_hi[23:0];
        r.noise_level       = hdr_hi[31:24];
        r.antenna_order     = hdr_hi[37:32];
        return r;
    endfunction

    task automatic unpack_byte(input logic [7:0] b);
        logic [31:0] acc;
        int          cnt;
        int          nrx;
        int          ntx;
        int          len;
        bit          ok;
        nrx = int'(hdr_lo[55:48]);
        ntx = int'(hdr_lo[63:56]);
        case (pstate)
            HUNTING:
            begin
                if (b == code_model)
                begin
                    pstate = IN_HEADER;
                    pos    = 0;
                    hdr_lo = '0;
                    hdr_hi = '0;
                end
            end
            IN_HEADER:
            begin
                // bytes 6, 7, 14, 18 and 19 are dropped
                if (pos <= 5)
                    hdr_lo[pos*8 +: 8] = b;
                else if (pos == 8)
                    hdr_lo[55:48] = b;
                else if (pos == 9)
                    hdr_lo[63:56] = b;
                else if (pos >= 10 && pos <= 13)
                    hdr_hi[(pos-10)*8 +: 8] = b;
                else if (pos == 15)
                    hdr_hi[39:32] = b;
                else if (pos == 16 || pos == 17)
                    hdr_hi[40+(pos-16)*8 +: 8] = b;
                pos++;
                if (pos == csibf_pkg::HEADER_BYTES)
                begin
                    nrx = int'(hdr_lo[55:48]);
                    ntx = int'(hdr_lo[63:56]);
                    len = int'(hdr_hi[55:40]);
                    ok  = (nrx <= csibf_pkg::MAX_ANTENNAS) && (ntx <= csibf_pkg::MAX_ANTENNAS)
                          && ((csibf_pkg::SUBCARRIERS * (nrx * ntx * 16 + 3) + 7) / 8 == len);
                    pos = 0;
                    if (!ok)
                    begin
                        pstate = HUNTING;
                        expected_results.push_back(
                            build_result(csibf_pkg::KIND_MISMATCH, 8'd0, 5'd0, 4'd0, 1'b0));
                    end
                    else
                    begin
                        pay_len   = 16'(len);
                        bit_buf   = '0;
                        bit_cnt   = 0;
                        skip_left = csibf_pkg::SKIP_BITS;
                        sc_idx    = 0;
                        pair_idx  = 0;
                        imag_q    = 1'b0;
                        pstate    = (len == 0) ? HUNTING : IN_PAYLOAD;
                        expected_results.push_back(
                            build_result(csibf_pkg::KIND_HEADER, 8'd0, 5'd0, 4'd0, 1'b0));
                    end
                end
            end
            IN_PAYLOAD:
            begin
                // lsb-first bit stream, 3 pad bits ahead of each subcarrier
                acc = {16'd0, bit_buf} | (32'(b) << bit_cnt);
                cnt = bit_cnt + 8;
                if (nrx * ntx > 0 && sc_idx < csibf_pkg::SUBCARRIERS)
                begin
                    if (skip_left > 0 && cnt >= skip_left)
                    begin
                        acc       = acc >> skip_left;
                        cnt       = cnt - skip_left;
                        skip_left = 0;
                    end
                    if (skip_left == 0 && cnt >= 8)
                    begin
                        expected_results.push_back(build_result(csibf_pkg::KIND_VALUE,
                            acc[7:0], 5'(sc_idx), 4'(pair_idx), imag_q));
                        acc = acc >> 8;
                        cnt = cnt - 8;
                        if (imag_q)
                        begin
                            imag_q = 1'b0;
                            pair_idx++;
                            if (pair_idx >= nrx * ntx)
                            begin
                                pair_idx  = 0;
                                sc_idx++;
                                skip_left = csibf_pkg::SKIP_BITS;
                            end
                        end
                        else
                        begin
                            imag_q = 1'b1;
                        end
                    end
                end
                else
                begin
                    // trailing bits are thrown away
                    acc = '0;
                    cnt = 0;
                end
                bit_buf = acc[15:0];
                bit_cnt = cnt & 31;
                pos++;
                if (pos >= pay_len)
                    pstate = HUNTING;
            end
            default:
                pstate = HUNTING;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
            input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        stream_q.push_back(b);
        queued++;
    endtask

    // bytes seen while hunting, mostly kept off the record code
    task automatic queue_noise(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom);
            if (b == code_model && $urandom_range(0, 9) != 0)
                b = b ^ 8'h01;
            stream_q.push_back(b);
        end
    endtask

    // fill < 0 means random bytes, else all but counts and length take the fill
    task automatic queue_record(input int nrx, input int ntx, input int len_delta,
            input int hdr_fill, input int pay_fill);
        logic [15:0] len;
        logic [7:0]  b;
        len = 16'((csibf_pkg::SUBCARRIERS * (nrx * ntx * 16 + 3) + 7) / 8 + len_delta);
        push_byte(code_model);
        for (int i = 0; i < csibf_pkg::HEADER_BYTES; i++)
        begin
            case (i)
                8:       b = 8'(nrx);
                9:       b = 8'(ntx);
                16:      b = len[7:0];
                17:      b = len[15:8];
                default: b = (hdr_fill < 0) ? 8'($urandom) : 8'(hdr_fill);
            endcase
            push_byte(b);
        end
        if (nrx <= csibf_pkg::MAX_ANTENNAS && ntx <= csibf_pkg::MAX_ANTENNAS
                && len_delta == 0)
        begin
            for (int i = 0; i < int'(len); i++)
                push_byte((pay_fill < 0) ? 8'($urandom) : 8'(pay_fill));
        end
    endtask

    function automatic int pick_antennas();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        if (r < 60)
            return 1;
        if (r < 85)
            return 2;
        return 3;
    endfunction

    task automatic queue_random(input int n);
        int start_count;
        int r;
        int nrx;
        int ntx;
        int delta;
        start_count = queued;
        while (queued - start_count < n)
        begin
            r   = $urandom_range(0, 99);
            nrx = pick_antennas();
            ntx = pick_antennas();
            if (r < 65)
            begin
                queue_record(nrx, ntx, 0, -1, -1);
            end
            else if (r < 75)
            begin
                delta = $urandom_range(1, 40);
                if ($urandom_range(0, 1) == 1)
                    delta = -delta;
                queue_record(nrx, ntx, delta, -1, -1);
            end
            else if (r < 83)
            begin
                if ($urandom_range(0, 1) == 1)
                    queue_record($urandom_range(4, 255), $urandom_range(0, 255), 0, -1, -1);
                else
                    queue_record($urandom_range(0, 255), $urandom_range(4, 255), 0, -1, -1);
            end
            else
            begin
                queue_noise($urandom_range(1, 24));
            end
        end
    endtask

    // sampled at the falling edge, once the driver and monitor updates have landed
    task automatic wait_idle();
        while (stream_q.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // call right after a rising edge with the unpacker idle
    task automatic write_code(input logic [7:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        code_model = v;
    endtask

    // driver: one transaction per accepted byte, fed from stream_q
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'd0;
        end
        else
        begin
            if (in_valid && in_ready)
                unpack_byte(data_byte);
            if (!in_valid || in_ready)
            begin
                if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    in_valid  <= 1'b1;
                    data_byte <= stream_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_taken++;
                if (results_taken == HOLD_AFTER)
                    hold_left = HOLD_CYCLES;
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation waiting, kind %0d", kind);
                    errors++;
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    check_field("kind", want_res.kind, kind);
                    check_field("csi_value", want_res.csi_value, csi_value);
                    check_field("subcarrier", want_res.subcarrier, subcarrier);
                    check_field("pair_index", want_res.pair_index, pair_index);
                    check_field("is_imag", want_res.is_imag, is_imag);
                    check_field("timestamp", want_res.timestamp, timestamp);
                    check_field("beamforming_count", want_res.beamforming_count,
                                beamforming_count);
                    check_field("rx_antennas", want_res.rx_antennas, rx_antennas);
                    check_field("tx_antennas", want_res.tx_antennas, tx_antennas);
                    check_field("rssi_triplet", want_res.rssi_triplet, rssi_triplet);
                    check_field("noise_level", want_res.noise_level, noise_level);
                    check_field("antenna_order", want_res.antenna_order, antenna_order);
                end
            end
            // long hold-off so the unpacker fills up and stalls its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= STALL_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed records with the reset record code
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        stream_q.push_back(csibf_pkg::RECORD_CODE_RESET - 8'd1);
        stream_q.push_back(csibf_pkg::RECORD_CODE_RESET + 8'd1);
        queue_record(1, 1, 0, 8'hFF, 8'hFF);
        // too many antennas, then a record code right after the rejection
        queue_record(4, 1, 0, 8'h00, -1);
        // wrong length, header full of record codes
        queue_record(2, 2, 1, int'(csibf_pkg::RECORD_CODE_RESET), -1);
        // zero antenna pairs, payload made of record codes
        queue_record(0, 2, 0, -1, int'(csibf_pkg::RECORD_CODE_RESET));
        queue_record(3, 3, 0, -1, -1);
        wait_idle();

        write_code(8'h00);
        queue_random(100);
        wait_idle();

        write_code(8'hFF);
        queue_random(100);
        wait_idle();

        send_idle <= 54;
        recv_idle <= 26;
        write_code(8'($urandom));
        queue_random(100);
        wait_idle();

        write_code(csibf_pkg::RECORD_CODE_RESET);
        queue_random(100);
        wait_idle();

        send_idle <= 0;
        recv_idle <= 0;
        write_code(8'($urandom));
        queue_random(100);
        wait_idle();

        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
